// ===== design/rsts_pkg.sv =====
// ----------------------------------------------------------------------------
// Ratio slot table scheduler package
// Shared types and constants of the ratio slot table scheduler.
// ----------------------------------------------------------------------------
package rsts_pkg;

	// Table geometry. The table size is a power of two, so row arithmetic wraps by masking.
	localparam int TABLE_SIZE = 16;
	localparam int ROW_W      = $clog2(TABLE_SIZE);
	localparam int MASK_BITS  = 16;
	localparam int NUM_SLOTS  = (TABLE_SIZE < MASK_BITS) ? TABLE_SIZE : MASK_BITS;
	localparam int SLOT_W     = 4;

	// Field widths.
	localparam int ACTION_W = 2;
	localparam int RATIO_W  = 7;
	localparam int STATUS_W = 2;

	// Spread arithmetic: gap = GAP_DIVIDEND / ratio, offsets are scaled by RATIO_SCALE.
	localparam int GAP_W        = 14;
	localparam int DIV_STEPS    = GAP_W;
	localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
	localparam int GAP_DIVIDEND = 10000;
	localparam int RATIO_SCALE  = 100;
	localparam int RATIO_MAX    = 100;
	localparam int LIM_W        = RATIO_W + ROW_W;

	// Action codes.
	localparam logic [ACTION_W-1:0] ACT_ALLOC   = 2'd0;
	localparam logic [ACTION_W-1:0] ACT_RELEASE = 2'd1;
	localparam logic [ACTION_W-1:0] ACT_TICK    = 2'd2;

	// Status codes.
	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
	localparam logic [STATUS_W-1:0] ST_RATIO = 2'd2;

	typedef struct packed {
		logic [ACTION_W-1:0] action;
		logic [RATIO_W-1:0]  ratio_percent;
		logic [SLOT_W-1:0]   release_slot;
	} in_item_t;

	typedef struct packed {
		logic [STATUS_W-1:0]  status;
		logic [SLOT_W-1:0]    granted_slot;
		logic                 always_mode;
		logic [MASK_BITS-1:0] run_mask;
	} out_item_t;

endpackage

// ===== design/ratio_slot_table_scheduler_top.sv =====
// ----------------------------------------------------------------------------
// Ratio slot table scheduler
// Rotating table of per-round slot masks with allocate, release and tick.
// ----------------------------------------------------------------------------
//
//  Channel | Direction | Signals                       | Transfer when
//  --------+-----------+-------------------------------+----------------------
//  in      | inbound   | in_valid, in_stall, in_item   | in_valid && !in_stall
//  out     | outbound  | out_valid, out_stall, out_item| out_valid && !out_stall
//
// Release, tick and every rejected allocate go from the transfer straight to
// the hand-over state, which passes the result to the output register.
// A spread allocate runs the shared restoring divider twice (14 steps for the
// gap, 14 steps for its hundreds), passes through a set-up state, writes one
// table row per cycle for each mark and closes by moving the fill base on.
// An allocate of ratio 100 takes the path of a release. The hand-over waits
// while the output register holds a stalled result.
// Reset clears the slot mask, the whole table, the fill base and the round
// index at once. in_stall is high whenever an item is in work; a held result
// in the output register does not block the next transfer in.
module ratio_slot_table_scheduler_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  rsts_pkg::in_item_t in_item,
	output logic               out_valid,
	input  logic               out_stall,
	output rsts_pkg::out_item_t out_item
);

	// Sequencer states.
	localparam logic [2:0] S_IDLE   = 3'd0;
	localparam logic [2:0] S_DIVGAP = 3'd1;
	localparam logic [2:0] S_DIVHUN = 3'd2;
	localparam logic [2:0] S_SETUP  = 3'd3;
	localparam logic [2:0] S_SPREAD = 3'd4;
	localparam logic [2:0] S_FINISH = 3'd5;

	logic [2:0] state_q;

	// Architectural state.
	logic [rsts_pkg::MASK_BITS-1:0] rows_q [rsts_pkg::TABLE_SIZE];
	logic [rsts_pkg::MASK_BITS-1:0] in_use_q;
	logic [rsts_pkg::ROW_W-1:0]     fill_base_q;
	logic [rsts_pkg::ROW_W-1:0]     round_q;

	// Working registers of one allocate.
	logic [rsts_pkg::RATIO_W-1:0]   ratio_q;
	logic [rsts_pkg::MASK_BITS-1:0] bit_q;
	logic [rsts_pkg::GAP_W-1:0]     div_q;     // dividend in, quotient out
	logic [rsts_pkg::RATIO_W-1:0]   rem_q;     // partial remainder
	logic [rsts_pkg::DIV_CNT_W-1:0] cnt_q;
	logic [rsts_pkg::GAP_W-1:0]     gap_q;
	logic [rsts_pkg::RATIO_W-1:0]   gq_q;      // floor(gap / 100)
	logic [rsts_pkg::RATIO_W-1:0]   gr_q;      // gap mod 100
	logic [rsts_pkg::ROW_W-1:0]     off_q;     // row offset of the current mark
	logic [rsts_pkg::RATIO_W-1:0]   frac_q;    // fractional part of k * gap, in hundredths
	logic [rsts_pkg::LIM_W-1:0]     thr_q;     // (k + 1) * 100

	rsts_pkg::out_item_t res_q;
	rsts_pkg::out_item_t out_q;
	logic                out_valid_q;

	logic in_xfer;
	logic out_free;
	logic out_load;
	assign in_xfer  = in_valid && !in_stall;
	assign in_stall = (state_q != S_IDLE);
	assign out_free = !out_valid_q || !out_stall;
	assign out_load = (state_q == S_FINISH) && out_free;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	// Lowest free slot.
	logic                        free_found;
	logic [rsts_pkg::SLOT_W-1:0] free_slot;
	always_comb begin
		free_found = 1'b0;
		free_slot  = '0;
		for (int i = rsts_pkg::NUM_SLOTS - 1; i >= 0; i--) begin
			if (!in_use_q[i]) begin
				free_found = 1'b1;
				free_slot  = rsts_pkg::SLOT_W'(i);
			end
		end
	end

	// Decode of an incoming item: its immediate result, whether it claims a
	// slot and whether a spread has to follow.
	logic                ratio_bad;
	logic                idle_take;
	logic                idle_spread;
	rsts_pkg::out_item_t idle_res;
	always_comb begin
		ratio_bad   = (in_item.ratio_percent == '0) ||
			(in_item.ratio_percent > rsts_pkg::RATIO_W'(rsts_pkg::RATIO_MAX));
		idle_take   = 1'b0;
		idle_spread = 1'b0;
		idle_res    = '0;
		case (in_item.action)
			rsts_pkg::ACT_ALLOC: begin
				if (ratio_bad) begin
					idle_res.status = rsts_pkg::ST_RATIO;
				end else if (!free_found) begin
					idle_res.status = rsts_pkg::ST_FULL;
				end else begin
					idle_take             = 1'b1;
					idle_res.granted_slot = free_slot;
					if (in_item.ratio_percent ==
					    rsts_pkg::RATIO_W'(rsts_pkg::RATIO_MAX)) begin
						idle_res.always_mode = 1'b1;
					end else begin
						idle_spread = 1'b1;
					end
				end
			end
			rsts_pkg::ACT_TICK: begin
				idle_res.run_mask = rows_q[round_q];
			end
			default: begin
				// Release and the undefined action report an all-zero result.
			end
		endcase
	end

	// Shared restoring divider step: divisor is the latched ratio.
	logic [rsts_pkg::RATIO_W:0]   trial;
	logic                         q_bit;
	logic [rsts_pkg::RATIO_W-1:0] rem_next;
	always_comb begin
		trial    = {rem_q, div_q[rsts_pkg::GAP_W-1]};
		q_bit    = (trial >= {1'b0, ratio_q});
		rem_next = q_bit ? rsts_pkg::RATIO_W'(trial - {1'b0, ratio_q})
			: rsts_pkg::RATIO_W'(trial);
	end

	// Spread bookkeeping: the next mark's offset and fraction, and the mark limit.
	logic [rsts_pkg::RATIO_W:0]   frac_sum;
	logic                         frac_carry;
	logic [rsts_pkg::LIM_W-1:0]   mark_lim;
	logic [rsts_pkg::GAP_W-1:0]   gq_scaled;
	logic [rsts_pkg::ROW_W-1:0]   mark_row;
	always_comb begin
		frac_sum   = {1'b0, frac_q} + {1'b0, gr_q};
		frac_carry = (frac_sum >= (rsts_pkg::RATIO_W + 1)'(rsts_pkg::RATIO_SCALE));
		mark_lim   = {ratio_q, {rsts_pkg::ROW_W{1'b0}}};
		gq_scaled  = rsts_pkg::GAP_W'(div_q[rsts_pkg::RATIO_W-1:0])
			* rsts_pkg::GAP_W'(rsts_pkg::RATIO_SCALE);
		mark_row   = fill_base_q + off_q;
	end

	// Output register: loaded when the sequencer hands a result over, emptied
	// by a transfer out.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_q       <= res_q;
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			in_use_q    <= '0;
			fill_base_q <= '0;
			round_q     <= '0;
			for (int r = 0; r < rsts_pkg::TABLE_SIZE; r++) begin
				rows_q[r] <= '0;
			end
		end else begin
			case (state_q)
				S_IDLE: begin
					if (in_xfer) begin
						res_q   <= idle_res;
						ratio_q <= in_item.ratio_percent;
						state_q <= idle_spread ? S_DIVGAP : S_FINISH;
						if (idle_take) begin
							in_use_q[free_slot] <= 1'b1;
							bit_q <= rsts_pkg::MASK_BITS'(1) << free_slot;
						end
						if (idle_spread) begin
							div_q <= rsts_pkg::GAP_W'(rsts_pkg::GAP_DIVIDEND);
							rem_q <= '0;
							cnt_q <= '0;
						end
						if (in_item.action == rsts_pkg::ACT_RELEASE) begin
							for (int r = 0; r < rsts_pkg::TABLE_SIZE; r++) begin
								rows_q[r][in_item.release_slot] <= 1'b0;
							end
							in_use_q[in_item.release_slot] <= 1'b0;
						end
						if (in_item.action == rsts_pkg::ACT_TICK) begin
							round_q <= round_q + 1'b1;
						end
					end
				end
				S_DIVGAP, S_DIVHUN: begin
					if (cnt_q == rsts_pkg::DIV_CNT_W'(rsts_pkg::DIV_STEPS - 1) &&
					    state_q == S_DIVGAP) begin
						// Gap is known; next find its hundreds as 100 / ratio.
						gap_q   <= {div_q[rsts_pkg::GAP_W-2:0], q_bit};
						div_q   <= rsts_pkg::GAP_W'(rsts_pkg::RATIO_SCALE);
						rem_q   <= '0;
						cnt_q   <= '0;
						state_q <= S_DIVHUN;
					end else begin
						div_q <= {div_q[rsts_pkg::GAP_W-2:0], q_bit};
						rem_q <= rem_next;
						cnt_q <= cnt_q + 1'b1;
						if (cnt_q == rsts_pkg::DIV_CNT_W'(rsts_pkg::DIV_STEPS - 1)) begin
							state_q <= S_SETUP;
						end
					end
				end
				S_SETUP: begin
					gq_q    <= div_q[rsts_pkg::RATIO_W-1:0];
					gr_q    <= rsts_pkg::RATIO_W'(gap_q - gq_scaled);
					off_q   <= '0;
					frac_q  <= '0;
					thr_q   <= rsts_pkg::LIM_W'(rsts_pkg::RATIO_SCALE);
					state_q <= S_SPREAD;
				end
				S_SPREAD: begin
					if (thr_q <= mark_lim) begin
						rows_q[mark_row] <= rows_q[mark_row] | bit_q;
						off_q  <= off_q + gq_q[rsts_pkg::ROW_W-1:0]
							+ rsts_pkg::ROW_W'(frac_carry);
						frac_q <= frac_carry
							? rsts_pkg::RATIO_W'(frac_sum
								- (rsts_pkg::RATIO_W + 1)'(rsts_pkg::RATIO_SCALE))
							: rsts_pkg::RATIO_W'(frac_sum);
						thr_q  <= thr_q + rsts_pkg::LIM_W'(rsts_pkg::RATIO_SCALE);
					end else begin
						fill_base_q <= fill_base_q + 1'b1;
						state_q     <= S_FINISH;
					end
				end
				S_FINISH: begin
					// Hand the result over once the output register is free.
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

endmodule
